// File: sv/npts_pkg.sv
// Package for the nearest point table search block.
// Holds field widths, operation and state codes, and the empty-table defaults.
// No dependencies.
package npts_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 8;
  localparam int CAT_W = 3;
  localparam int IN_W  = 10;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int COORD_WIDTH_DEF = 10;

  localparam logic [CAT_W-1:0]       DEF_CATEGORY = 3'd3;
  localparam logic signed [IN_W-1:0] DEF_ZERO     = 10'sd0;
  localparam logic signed [IN_W-1:0] DEF_HALF     = 10'sd128;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_QRY_INT = 2'd1,
    OP_QRY_DOM = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

// File: sv/nearest_point_table_search_core.sv
// Top level of the nearest point table search block.
// Holds the point table memory, the scan sequencer and the distance pipeline.
// Depends on npts_pkg.
//
// Usage: one request channel (in_valid_i / in_stall_o) carries writes and
// queries; one result channel (out_valid_o / out_stall_i) carries one result
// per query. A write stores category and saturated coordinates at slot
// entry_id modulo TABLE_DEPTH; op code 3 is dropped.
// A query scans every slot through one read port, one slot per cycle, into a
// four-stage distance pipeline (difference, square, sum, compare); after the
// scan the pipeline drains and the result is loaded into the output register.
// The next request is taken once the result is loaded. The request channel
// is stalled while a query is in progress. The output register parts the two
// sides: a new request is taken while an earlier result still waits; a query
// that finishes while the receiver stalls holds in its last state until the
// output register is free.
// After reset a clearing pass marks every slot invalid, one slot per cycle,
// and no request is taken meanwhile.
// An empty table returns the neutral default with table_empty set.
module nearest_point_table_search_core #(
  parameter int TABLE_DEPTH = npts_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = npts_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [npts_pkg::OP_W-1:0]           op_i,
  input  logic [npts_pkg::ID_W-1:0]           entry_id_i,
  input  logic [npts_pkg::CAT_W-1:0]          category_i,
  input  logic signed [npts_pkg::IN_W-1:0]    valence_i,
  input  logic signed [npts_pkg::IN_W-1:0]    arousal_i,
  input  logic signed [npts_pkg::IN_W-1:0]    intensity_i,
  input  logic signed [npts_pkg::IN_W-1:0]    dominance_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [npts_pkg::ID_W-1:0]           nearest_id_o,
  output logic [npts_pkg::CAT_W-1:0]          nearest_category_o,
  output logic signed [npts_pkg::IN_W-1:0]    nearest_valence_o,
  output logic signed [npts_pkg::IN_W-1:0]    nearest_arousal_o,
  output logic signed [npts_pkg::IN_W-1:0]    nearest_intensity_o,
  output logic signed [npts_pkg::IN_W-1:0]    nearest_dominance_o,
  output logic                                table_empty_o
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EXT_W  = (COORD_WIDTH > npts_pkg::IN_W) ? COORD_WIDTH : npts_pkg::IN_W;
  localparam int SQ_W   = 2 * EXT_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int ID_CNT = 2 ** npts_pkg::ID_W;

  localparam logic signed [EXT_W-1:0] C_HI = EXT_W'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [EXT_W-1:0] C_LO = ~C_HI;
  localparam logic [IDX_W-1:0]        LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic                              vld;
    logic [npts_pkg::CAT_W-1:0]        cat;
    logic signed [COORD_WIDTH-1:0]     val;
    logic signed [COORD_WIDTH-1:0]     aro;
    logic signed [COORD_WIDTH-1:0]     inten;
    logic signed [COORD_WIDTH-1:0]     dom;
  } entry_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [npts_pkg::IN_W-1:0] x
  );
    logic signed [EXT_W-1:0] xe;
    xe = EXT_W'(x);
    if (xe > C_HI) begin
      xe = C_HI;
    end else if (xe < C_LO) begin
      xe = C_LO;
    end
    return COORD_WIDTH'(xe);
  endfunction

  function automatic logic [EXT_W-1:0] abs_diff(
    input logic signed [EXT_W-1:0] a,
    input logic signed [EXT_W-1:0] b
  );
    logic signed [EXT_W:0] d;
    d = (EXT_W+1)'(a) - (EXT_W+1)'(b);
    if (d[EXT_W]) begin
      d = -d;
    end
    return d[EXT_W-1:0];
  endfunction

  logic [IDX_W-1:0] slot_lut [ID_CNT];

  for (genvar k = 0; k < ID_CNT; k++) begin : g_slot_lut
    assign slot_lut[k] = IDX_W'(k % TABLE_DEPTH);
  end

  npts_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  logic in_acc;
  logic is_write;
  logic is_query;
  logic pipe_busy;
  logic load_out;
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t mem_wdata;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  logic [IDX_W-1:0] rd_slot_q;
  logic rd_vld_q;

  logic signed [EXT_W-1:0] q_val_q, q_aro_q, q_third_q;
  logic q_dom_q;

  logic a_vld_q;
  entry_t a_ent_q;
  logic [IDX_W-1:0] a_slot_q;
  logic [EXT_W-1:0] a_dv_q, a_da_q, a_dt_q;

  logic b_vld_q;
  entry_t b_ent_q;
  logic [IDX_W-1:0] b_slot_q;
  logic [SQ_W-1:0] b_sv_q, b_sa_q, b_st_q;

  logic c_vld_q;
  entry_t c_ent_q;
  logic [IDX_W-1:0] c_slot_q;
  logic [DIST_W-1:0] c_dist_q;

  logic best_found_q;
  logic best_upd;
  entry_t best_ent_q;
  logic [IDX_W-1:0] best_slot_q;
  logic [DIST_W-1:0] best_dist_q;

  logic out_valid_q;

  always_comb begin
    is_write = 1'b0;
    is_query = 1'b0;
    case (npts_pkg::op_e'(op_i))
      npts_pkg::OP_WRITE: begin
        is_write = 1'b1;
      end
      npts_pkg::OP_QRY_INT, npts_pkg::OP_QRY_DOM: begin
        is_query = 1'b1;
      end
      default: begin
        is_write = 1'b0;
        is_query = 1'b0;
      end
    endcase
  end

  assign pipe_busy = rd_vld_q | a_vld_q | b_vld_q | c_vld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      npts_pkg::ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = npts_pkg::ST_IDLE;
        end
      end
      npts_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && is_query) begin
          state_d = npts_pkg::ST_SCAN;
        end
      end
      npts_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = npts_pkg::ST_DRAIN;
        end
      end
      npts_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = npts_pkg::ST_DONE;
        end
      end
      npts_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = npts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = npts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_lut[entry_id_i];
    mem_wdata  = '{vld: 1'b1, cat: category_i, val: sat_coord(valence_i),
                   aro: sat_coord(arousal_i), inten: sat_coord(intensity_i),
                   dom: sat_coord(dominance_i)};
    case (state_q)
      npts_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
      end
      npts_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_we     = in_valid_i && is_write;
      end
      npts_pkg::ST_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npts_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= mem_q[cnt_q];
    rd_slot_q <= cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      q_val_q   <= EXT_W'(valence_i);
      q_aro_q   <= EXT_W'(arousal_i);
      q_dom_q   <= (npts_pkg::op_e'(op_i) == npts_pkg::OP_QRY_DOM);
      q_third_q <= (npts_pkg::op_e'(op_i) == npts_pkg::OP_QRY_DOM) ?
                   EXT_W'(dominance_i) : EXT_W'(intensity_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == npts_pkg::ST_SCAN);
      a_vld_q  <= rd_vld_q;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ent_q  <= rd_q;
    a_slot_q <= rd_slot_q;
    a_dv_q   <= abs_diff(EXT_W'(rd_q.val), q_val_q);
    a_da_q   <= abs_diff(EXT_W'(rd_q.aro), q_aro_q);
    a_dt_q   <= abs_diff(q_dom_q ? EXT_W'(rd_q.dom) : EXT_W'(rd_q.inten), q_third_q);

    b_ent_q  <= a_ent_q;
    b_slot_q <= a_slot_q;
    b_sv_q   <= SQ_W'(a_dv_q) * SQ_W'(a_dv_q);
    b_sa_q   <= SQ_W'(a_da_q) * SQ_W'(a_da_q);
    b_st_q   <= SQ_W'(a_dt_q) * SQ_W'(a_dt_q);

    c_ent_q  <= b_ent_q;
    c_slot_q <= b_slot_q;
    c_dist_q <= DIST_W'(b_sv_q) + DIST_W'(b_sa_q) + DIST_W'(b_st_q);
  end

  assign best_upd = c_vld_q && c_ent_q.vld && (!best_found_q || (c_dist_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (in_acc && is_query) begin
      best_found_q <= 1'b0;
    end else if (best_upd) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_upd) begin
      best_ent_q  <= c_ent_q;
      best_slot_q <= c_slot_q;
      best_dist_q <= c_dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (best_found_q) begin
        nearest_id_o        <= npts_pkg::ID_W'(best_slot_q);
        nearest_category_o  <= best_ent_q.cat;
        nearest_valence_o   <= npts_pkg::IN_W'(best_ent_q.val);
        nearest_arousal_o   <= npts_pkg::IN_W'(best_ent_q.aro);
        nearest_intensity_o <= npts_pkg::IN_W'(best_ent_q.inten);
        nearest_dominance_o <= npts_pkg::IN_W'(best_ent_q.dom);
        table_empty_o       <= 1'b0;
      end else begin
        nearest_id_o        <= '0;
        nearest_category_o  <= npts_pkg::DEF_CATEGORY;
        nearest_valence_o   <= npts_pkg::DEF_ZERO;
        nearest_arousal_o   <= npts_pkg::DEF_HALF;
        nearest_intensity_o <= npts_pkg::DEF_HALF;
        nearest_dominance_o <= npts_pkg::DEF_HALF;
        table_empty_o       <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: tb/sv/nearest_point_checker.sv
// Checker for the nearest point table search block: keeps its own copy of the point table,
// predicts the nearest entry for each accepted query and compares every accepted result.
// Depends on npts_pkg.
module nearest_point_checker #(
  parameter int TABLE_DEPTH = npts_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = npts_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [npts_pkg::OP_W-1:0]           op_i,
  input  logic [npts_pkg::ID_W-1:0]           entry_id_i,
  input  logic [npts_pkg::CAT_W-1:0]          category_i,
  input  logic signed [npts_pkg::IN_W-1:0]    valence_i,
  input  logic signed [npts_pkg::IN_W-1:0]    arousal_i,
  input  logic signed [npts_pkg::IN_W-1:0]    intensity_i,
  input  logic signed [npts_pkg::IN_W-1:0]    dominance_i,

  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [npts_pkg::ID_W-1:0]           nearest_id_i,
  input  logic [npts_pkg::CAT_W-1:0]          nearest_category_i,
  input  logic signed [npts_pkg::IN_W-1:0]    nearest_valence_i,
  input  logic signed [npts_pkg::IN_W-1:0]    nearest_arousal_i,
  input  logic signed [npts_pkg::IN_W-1:0]    nearest_intensity_i,
  input  logic signed [npts_pkg::IN_W-1:0]    nearest_dominance_i,
  input  logic                                table_empty_i,

  output int                                  fail_count_o,
  output int                                  queries_waiting_o
);
  import npts_pkg::*;

  typedef struct {
    logic [CAT_W-1:0]       cat;
    logic signed [IN_W-1:0] val;
    logic signed [IN_W-1:0] aro;
    logic signed [IN_W-1:0] inten;
    logic signed [IN_W-1:0] dom;
  } point_t;

  typedef struct {
    logic [ID_W-1:0] id;
    point_t          pt;
    logic            empty;
  } nearest_t;

  point_t   point_table [TABLE_DEPTH];
  bit       slot_used [TABLE_DEPTH];
  nearest_t nearest_expected [$];
  int       mismatches = 0;
  int       queries_waiting = 0;

  assign fail_count_o      = mismatches;
  assign queries_waiting_o = queries_waiting;

  function automatic logic signed [IN_W-1:0] clamp_coord(logic signed [IN_W-1:0] raw);
    int hi;
    int lo;
    int v;
    hi = (1 << (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    v  = raw;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[IN_W-1:0];
  endfunction

  function automatic longint sq_diff(logic signed [IN_W-1:0] a, logic signed [IN_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic nearest_t find_nearest(logic [OP_W-1:0] qop,
                                            logic signed [IN_W-1:0] qv,
                                            logic signed [IN_W-1:0] qa,
                                            logic signed [IN_W-1:0] qi,
                                            logic signed [IN_W-1:0] qd);
    nearest_t best;
    longint   best_dist;
    longint   cand_dist;
    bit       found;
    found        = 1'b0;
    best_dist    = 0;
    best.id      = '0;
    best.pt.cat  = DEF_CATEGORY;
    best.pt.val  = DEF_ZERO;
    best.pt.aro  = DEF_HALF;
    best.pt.inten = DEF_HALF;
    best.pt.dom  = DEF_HALF;
    best.empty   = 1'b1;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (!slot_used[k]) continue;
      cand_dist = sq_diff(point_table[k].val, qv) + sq_diff(point_table[k].aro, qa) +
                  ((qop == OP_QRY_INT) ? sq_diff(point_table[k].inten, qi)
                                       : sq_diff(point_table[k].dom, qd));
      if (!found || cand_dist < best_dist) begin
        found     = 1'b1;
        best_dist = cand_dist;
        best.id   = ID_W'(k);
        best.pt   = point_table[k];
        best.empty = 1'b0;
      end
    end
    return best;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] expected,
                                        logic signed [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    nearest_t exp_res;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (nearest_expected.size() == 0) begin
          $error("result with no query waiting: nearest_id %0d", nearest_id_i);
          mismatches++;
        end else begin
          exp_res = nearest_expected.pop_front();
          compare_field("nearest_id", 32'(exp_res.id), 32'(nearest_id_i));
          compare_field("nearest_category", 32'(exp_res.pt.cat), 32'(nearest_category_i));
          compare_field("nearest_valence", 32'(exp_res.pt.val), 32'(nearest_valence_i));
          compare_field("nearest_arousal", 32'(exp_res.pt.aro), 32'(nearest_arousal_i));
          compare_field("nearest_intensity", 32'(exp_res.pt.inten),
                        32'(nearest_intensity_i));
          compare_field("nearest_dominance", 32'(exp_res.pt.dom), 32'(nearest_dominance_i));
          compare_field("table_empty", 32'(exp_res.empty), 32'(table_empty_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_WRITE) begin
          point_table[entry_id_i % TABLE_DEPTH] = '{category_i, clamp_coord(valence_i),
                                                   clamp_coord(arousal_i),
                                                   clamp_coord(intensity_i),
                                                   clamp_coord(dominance_i)};
          slot_used[entry_id_i % TABLE_DEPTH] = 1'b1;
        end else if (op_i == OP_QRY_INT || op_i == OP_QRY_DOM) begin
          nearest_expected.insert(nearest_expected.size(),
                                  find_nearest(op_i, valence_i, arousal_i,
                                               intensity_i, dominance_i));
        end
      end
      queries_waiting = nearest_expected.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the nearest point table search testbench: clock, reset, request and result
// stimulus, and the final verdict. Depends on npts_pkg, nearest_point_table_search_core
// and nearest_point_checker.
module tb_top;
  import npts_pkg::*;

  localparam int              TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int              SCAN_CYCLES   = TABLE_DEPTH + 7;
  localparam int              RANDOM_REQS   = 1530;
  localparam int              QUIET_TAIL    = 150;
  localparam int              HOLD_CYCLES   = 4 * SCAN_CYCLES;
  localparam int              SETTLE_CYCLES = 2 * SCAN_CYCLES;
  localparam int              DRAIN_LIMIT   = 20 * SCAN_CYCLES;
  localparam longint          RUN_LIMIT     = 30_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam int              COORD_MAX     = (1 << (IN_W - 1)) - 1;
  localparam int              COORD_MIN     = -(1 << (IN_W - 1));

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        op;
  logic [ID_W-1:0]        entry_id;
  logic [CAT_W-1:0]       category;
  logic signed [IN_W-1:0] valence;
  logic signed [IN_W-1:0] arousal;
  logic signed [IN_W-1:0] intensity;
  logic signed [IN_W-1:0] dominance;
  logic                   out_valid;
  logic                   out_stall;
  logic [ID_W-1:0]        nearest_id;
  logic [CAT_W-1:0]       nearest_category;
  logic signed [IN_W-1:0] nearest_valence;
  logic signed [IN_W-1:0] nearest_arousal;
  logic signed [IN_W-1:0] nearest_intensity;
  logic signed [IN_W-1:0] nearest_dominance;
  logic                   table_empty;
  int                     fail_count;
  int                     queries_waiting;
  bit                     quiet_tail;
  bit                     hold_off_req;

  nearest_point_table_search_core DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .op_i                (op),
    .entry_id_i          (entry_id),
    .category_i          (category),
    .valence_i           (valence),
    .arousal_i           (arousal),
    .intensity_i         (intensity),
    .dominance_i         (dominance),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .nearest_id_o        (nearest_id),
    .nearest_category_o  (nearest_category),
    .nearest_valence_o   (nearest_valence),
    .nearest_arousal_o   (nearest_arousal),
    .nearest_intensity_o (nearest_intensity),
    .nearest_dominance_o (nearest_dominance),
    .table_empty_o       (table_empty)
  );

  nearest_point_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .op_i                (op),
    .entry_id_i          (entry_id),
    .category_i          (category),
    .valence_i           (valence),
    .arousal_i           (arousal),
    .intensity_i         (intensity),
    .dominance_i         (dominance),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .nearest_id_i        (nearest_id),
    .nearest_category_i  (nearest_category),
    .nearest_valence_i   (nearest_valence),
    .nearest_arousal_i   (nearest_arousal),
    .nearest_intensity_i (nearest_intensity),
    .nearest_dominance_i (nearest_dominance),
    .table_empty_i       (table_empty),
    .fail_count_o        (fail_count),
    .queries_waiting_o   (queries_waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(RUN_LIMIT);
    $display("nearest_point_table_search_core regression: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int span;
    bit held;
    out_stall = 1'b0;
    held      = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 19);
        repeat (span - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 30);
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  task automatic send_req(input logic [OP_W-1:0] req_op, input logic [ID_W-1:0] req_id,
                          input logic [CAT_W-1:0] req_cat,
                          input logic signed [IN_W-1:0] req_v,
                          input logic signed [IN_W-1:0] req_a,
                          input logic signed [IN_W-1:0] req_i,
                          input logic signed [IN_W-1:0] req_d);
    int gap;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= req_op;
    entry_id  <= req_id;
    category  <= req_cat;
    valence   <= req_v;
    arousal   <= req_a;
    intensity <= req_i;
    dominance <= req_d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_point(input logic [ID_W-1:0] id, input logic [CAT_W-1:0] cat,
                             input int v, input int a, input int i, input int d);
    send_req(OP_WRITE, id, cat, IN_W'(v), IN_W'(a), IN_W'(i), IN_W'(d));
  endtask

  task automatic query_point(input logic [OP_W-1:0] qop, input int v, input int a,
                             input int third);
    send_req(qop, ID_W'($urandom), CAT_W'($urandom), IN_W'(v), IN_W'(a), IN_W'(third),
             IN_W'(third));
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return IN_W'(COORD_MIN);
      1:       return IN_W'(COORD_MAX);
      2, 3:    return IN_W'(int'($urandom_range(0, 4)) * 128 - 256);
      default: return IN_W'($urandom_range(0, (1 << IN_W) - 1));
    endcase
  endfunction

  initial begin
    int unsigned            pick;
    logic [OP_W-1:0]        rop;
    int                     waited;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    op           = OP_WRITE;
    entry_id     = '0;
    category     = '0;
    valence      = '0;
    arousal      = '0;
    intensity    = '0;
    dominance    = '0;
    quiet_tail   = 1'b0;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, dropped op code
    query_point(OP_QRY_INT, 0, 0, 0);
    query_point(OP_QRY_DOM, COORD_MAX, COORD_MIN, COORD_MAX);
    send_req(OP_UNUSED, 8'd9, 3'd4, '0, '0, '0, '0);
    // extreme corners
    write_point(8'd255, 3'd7, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    write_point(8'd0, 3'd0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    query_point(OP_QRY_INT, COORD_MAX, COORD_MAX, COORD_MAX);
    query_point(OP_QRY_DOM, COORD_MIN, COORD_MIN, COORD_MIN);
    // overwrite an existing slot
    write_point(8'd0, 3'd5, 0, 0, 0, 0);
    query_point(OP_QRY_INT, 0, 0, 0);
    // equal distance from two points, lower id wins
    write_point(8'd100, 3'd6, 350, 0, 0, 0);
    write_point(8'd60, 3'd1, 250, 0, 0, 0);
    query_point(OP_QRY_INT, 300, 0, 0);
    // identical points
    write_point(8'd150, 3'd2, -200, -200, -200, -200);
    write_point(8'd30, 3'd4, -200, -200, -200, -200);
    query_point(OP_QRY_DOM, -200, -200, -200);
    // third axis selects intensity or dominance
    write_point(8'd7, 3'd3, -400, 400, 100, -400);
    write_point(8'd8, 3'd2, -400, 400, -400, 100);
    query_point(OP_QRY_INT, -400, 400, 100);
    query_point(OP_QRY_DOM, -400, 400, 100);
    send_req(OP_UNUSED, 8'd255, 3'd7, '1, '1, '1, '1);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 4) hold_off_req = 1'b1;
      if (n == RANDOM_REQS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (queries_waiting != 0) @(negedge clk);
      end
      if (n == RANDOM_REQS - QUIET_TAIL) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50) rop = OP_WRITE;
      else if (pick < 72) rop = OP_QRY_INT;
      else if (pick < 94) rop = OP_QRY_DOM;
      else rop = OP_UNUSED;
      send_req(rop, ID_W'($urandom_range(0, 255)), CAT_W'($urandom_range(0, 7)),
               rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (queries_waiting != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && queries_waiting == 0) begin
      $display("nearest_point_table_search_core regression: pass");
    end else begin
      $display("nearest_point_table_search_core regression: fail");
    end
    $finish;
  end

endmodule
